/* hdl/vnf_pkg.sv */
// ============================================================================
// vnf_pkg: shared constants, types and helpers of the value-noise tile classifier
// Widths, hash and fade constants, pipeline stage numbering, register map and
// the configuration bundle that travels from the register block to the core.
// ============================================================================
package vnf_pkg;

   // Noise and grid dimensions.
   localparam int OCTAVES     = 5;
   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;

   // Item fields.
   localparam int COORD_W = 8;
   localparam int CLASS_W = 2;

   // Register fields.
   localparam int SEED_W  = 32;
   localparam int SCALE_W = 16;
   localparam int LIMIT_W = 17;

   // Q.16 positions: coordinate times scale, then shifted left per octave.
   localparam int FRAC_W = 16;
   localparam int POS_W  = COORD_W + SCALE_W;
   localparam int LPOS_W = POS_W + OCTAVES - 1;

   // Corner values and blends lie in [-1, 1] in Q.16.
   localparam int VALUE_W = FRAC_W + 2;
   localparam int FADE_W  = FRAC_W + 2;
   localparam int SUM_W   = VALUE_W + OCTAVES;
   localparam int CMP_W   = LIMIT_W + 2 + OCTAVES;

   localparam int ONE_Q16  = 65536;
   localparam int FADE_A_K = 15 * ONE_Q16;
   localparam int FADE_B_K = 10 * ONE_Q16;

   // Lattice hash.
   localparam logic [31:0] HASH_MUL_Y = 32'd57;
   localparam logic [31:0] HASH_MUL_S = 32'd131;
   localparam int          HASH_SHIFT = 13;
   localparam logic [31:0] HASH_SQ    = 32'd15731;
   localparam logic [31:0] HASH_LIN   = 32'd789221;
   localparam logic [31:0] HASH_OFS   = 32'd1376312589;
   localparam int          SEED_STEP  = 997;

   // Pipeline stages, in the order an item visits them.
   localparam int ST_POS     = 0;
   localparam int ST_HASH    = 1;
   localparam int ST_SQUARE  = 2;
   localparam int ST_POLY    = 3;
   localparam int ST_CORNER  = 4;
   localparam int ST_XLERP   = 5;
   localparam int ST_YLERP   = 6;
   localparam int ST_OCTAVE  = 7;
   localparam int ST_SUM     = 8;
   localparam int ST_CLASS   = 9;
   localparam int NUM_STAGES = 10;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   // Register map.
   localparam int NUM_REGS   = 4;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS) + 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_SEED       = 2'd0,
      REG_SCALE      = 2'd1,
      REG_DIRT_LIMIT = 2'd2,
      REG_TREE_LIMIT = 2'd3
   } reg_index_type;

   localparam logic [SEED_W-1:0]  SEED_RST       = 32'd0;
   localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd3932;
   localparam logic [LIMIT_W-1:0] DIRT_LIMIT_RST = 17'd47186;
   localparam logic [LIMIT_W-1:0] TREE_LIMIT_RST = 17'd57672;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_DIRT = 2'd0,
      CLASS_TREE = 2'd1,
      CLASS_ROCK = 2'd2
   } tile_class_type;

   typedef struct packed {
      logic [SEED_W-1:0]         seed;
      logic [SCALE_W-1:0]        scale;
      logic signed [CMP_W-1:0]   dirt_thr;
      logic signed [CMP_W-1:0]   tree_thr;
   } cfg_type;

   // Maps a Q1.16 limit into octave-sum units: (2^OCTAVES - 1) * (2L - 1.0).
   function automatic logic signed [CMP_W-1:0] limit_to_thr(input logic [LIMIT_W-1:0] limit);
      logic signed [CMP_W-1:0] base;
      base = signed'(CMP_W'({limit, 1'b0})) - signed'(CMP_W'(ONE_Q16));
      return (base <<< OCTAVES) - base;
   endfunction

endpackage

/* hdl/vnf_if.sv */
// ============================================================================
// vnf_if: item channels of the value-noise tile classifier
// Coordinate channel into the core and class channel out of it, each with a
// valid/ready handshake.
// ============================================================================
interface vnf_req_if;
   logic                       valid;
   logic                       ready;
   logic [vnf_pkg::COORD_W-1:0] column;
   logic [vnf_pkg::COORD_W-1:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);
endinterface

interface vnf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vnf_pkg::CLASS_W-1:0] tile_class;

   modport source (output valid, output tile_class, input ready);
   modport sink   (input valid, input tile_class, output ready);
endinterface

/* hdl/vnf_csr.sv */
// ============================================================================
// vnf_csr: configuration registers
// APB-style register block for seed, scale and the two class limits; the
// limits are kept in sum units as well.
// ============================================================================
module vnf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vnf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [vnf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [vnf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output vnf_pkg::cfg_type                 cfg
);

   logic [vnf_pkg::SEED_W-1:0]  seed_ff;
   logic [vnf_pkg::SCALE_W-1:0] scale_ff;
   logic [vnf_pkg::LIMIT_W-1:0] dirt_limit_ff;
   logic [vnf_pkg::LIMIT_W-1:0] tree_limit_ff;
   logic signed [vnf_pkg::CMP_W-1:0] dirt_thr_ff;
   logic signed [vnf_pkg::CMP_W-1:0] tree_thr_ff;
   logic                  wr_en;
   vnf_pkg::reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = vnf_pkg::reg_index_type'(paddr[vnf_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= vnf_pkg::SEED_RST;
         scale_ff      <= vnf_pkg::SCALE_RST;
         dirt_limit_ff <= vnf_pkg::DIRT_LIMIT_RST;
         tree_limit_ff <= vnf_pkg::TREE_LIMIT_RST;
         dirt_thr_ff   <= vnf_pkg::limit_to_thr(vnf_pkg::DIRT_LIMIT_RST);
         tree_thr_ff   <= vnf_pkg::limit_to_thr(vnf_pkg::TREE_LIMIT_RST);
      end else begin
         dirt_thr_ff <= vnf_pkg::limit_to_thr(dirt_limit_ff);
         tree_thr_ff <= vnf_pkg::limit_to_thr(tree_limit_ff);
         if (wr_en) begin
            unique case (idx)
               vnf_pkg::REG_SEED:       seed_ff       <= pwdata[vnf_pkg::SEED_W-1:0];
               vnf_pkg::REG_SCALE:      scale_ff      <= pwdata[vnf_pkg::SCALE_W-1:0];
               vnf_pkg::REG_DIRT_LIMIT: dirt_limit_ff <= pwdata[vnf_pkg::LIMIT_W-1:0];
               vnf_pkg::REG_TREE_LIMIT: tree_limit_ff <= pwdata[vnf_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         vnf_pkg::REG_SEED:       prdata = vnf_pkg::CSR_DATA_W'(seed_ff);
         vnf_pkg::REG_SCALE:      prdata = vnf_pkg::CSR_DATA_W'(scale_ff);
         vnf_pkg::REG_DIRT_LIMIT: prdata = vnf_pkg::CSR_DATA_W'(dirt_limit_ff);
         vnf_pkg::REG_TREE_LIMIT: prdata = vnf_pkg::CSR_DATA_W'(tree_limit_ff);
         default:                 prdata = '0;
      endcase
   end

   assign cfg.seed     = seed_ff;
   assign cfg.scale    = scale_ff;
   assign cfg.dirt_thr = dirt_thr_ff;
   assign cfg.tree_thr = tree_thr_ff;

endmodule

/* hdl/vnf_fade.sv */
// ============================================================================
// vnf_fade: smootherstep fade
// Four-stage pipeline for 6f^5 - 15f^4 + 10f^3 in Q.16 with floor rounding.
// ============================================================================
module vnf_fade (
   input  logic                                clock,
   input  vnf_pkg::stage_en_type               en,
   input  logic [vnf_pkg::FRAC_W-1:0]          frac,
   output logic signed [vnf_pkg::FADE_W-1:0]   fade
);

   localparam int A_W  = vnf_pkg::FRAC_W + 6;
   localparam int FA_W = vnf_pkg::FRAC_W + 1 + A_W;
   localparam int SQ_W = 2 * vnf_pkg::FRAC_W;

   logic signed [A_W-1:0]  a_in;
   logic signed [FA_W-1:0] fa_ff;
   logic [SQ_W-1:0]        ff_ff;
   logic [vnf_pkg::FRAC_W-1:0] f_ff;
   logic signed [A_W-1:0]  b_in;
   logic signed [A_W-1:0]  b_ff;
   logic [SQ_W-1:0]        d_ff;
   logic signed [FA_W-1:0] sp_ff;
   logic signed [vnf_pkg::FADE_W-1:0] fade_ff;

   // a = 6f - 15.0, always negative over the fraction range.
   assign a_in = signed'((A_W'(frac) << 2) + (A_W'(frac) << 1) - A_W'(vnf_pkg::FADE_A_K));
   assign b_in = A_W'(fa_ff >>> vnf_pkg::FRAC_W) + A_W'(vnf_pkg::FADE_B_K);

   always_ff @(posedge clock) begin
      if (en[vnf_pkg::ST_HASH]) begin
         fa_ff <= signed'({1'b0, frac}) * a_in;
         ff_ff <= frac * frac;
         f_ff  <= frac;
      end
      if (en[vnf_pkg::ST_SQUARE]) begin
         b_ff <= b_in;
         d_ff <= ff_ff[SQ_W-1:vnf_pkg::FRAC_W] * f_ff;
      end
      if (en[vnf_pkg::ST_POLY]) begin
         sp_ff <= signed'({1'b0, d_ff[SQ_W-1:vnf_pkg::FRAC_W]}) * b_ff;
      end
      if (en[vnf_pkg::ST_CORNER]) begin
         fade_ff <= vnf_pkg::FADE_W'(sp_ff >>> vnf_pkg::FRAC_W);
      end
   end

   assign fade = fade_ff;

endmodule

/* hdl/vnf_hash.sv */
// ============================================================================
// vnf_hash: lattice corner hash
// Four-stage pipeline of the 32-bit wrapping integer hash, one multiply per
// stage after the first, mapped to a Q.16 corner value in [-1, 1].
// ============================================================================
module vnf_hash (
   input  logic                                 clock,
   input  vnf_pkg::stage_en_type                en,
   input  logic [31:0]                          x,
   input  logic [31:0]                          y,
   input  logic [31:0]                          seed,
   output logic signed [vnf_pkg::VALUE_W-1:0]   value
);

   logic [31:0] n_in;
   logic [31:0] n2_in;
   logic [31:0] n2_ff;
   logic [31:0] n2b_ff;
   logic [31:0] n2c_ff;
   logic [31:0] nn_ff;
   logic [31:0] t_ff;
   logic [31:0] h_full;
   logic [30:0] h_ff;
   logic [31:0] span;
   logic signed [vnf_pkg::VALUE_W:0] value_wide;

   assign n_in   = x + y * vnf_pkg::HASH_MUL_Y + seed * vnf_pkg::HASH_MUL_S;
   assign n2_in  = (n_in << vnf_pkg::HASH_SHIFT) ^ n_in;
   assign h_full = n2c_ff * t_ff + vnf_pkg::HASH_OFS;

   always_ff @(posedge clock) begin
      if (en[vnf_pkg::ST_HASH]) begin
         n2_ff <= n2_in;
      end
      if (en[vnf_pkg::ST_SQUARE]) begin
         nn_ff  <= n2_ff * n2_ff;
         n2b_ff <= n2_ff;
      end
      if (en[vnf_pkg::ST_POLY]) begin
         t_ff   <= nn_ff * vnf_pkg::HASH_SQ + vnf_pkg::HASH_LIN;
         n2c_ff <= n2b_ff;
      end
      if (en[vnf_pkg::ST_CORNER]) begin
         h_ff <= h_full[30:0];
      end
   end

   // The hash is at most 2^31 - 1, so the span lies in [1, 2^31].
   assign span       = 32'h8000_0000 - {1'b0, h_ff};
   assign value_wide = signed'({1'b0, span[31:14]}) - signed'((vnf_pkg::VALUE_W+1)'(vnf_pkg::ONE_Q16));
   assign value      = vnf_pkg::VALUE_W'(value_wide);

endmodule

/* hdl/vnf_octave_lane.sv */
// ============================================================================
// vnf_octave_lane: one noise octave
// Hashes the four lattice corners around a sample point, fades both
// fractions and blends the corners bilinearly.
// ============================================================================
module vnf_octave_lane (
   input  logic                                 clock,
   input  vnf_pkg::stage_en_type                en,
   input  logic [vnf_pkg::LPOS_W-1:0]           pos_x,
   input  logic [vnf_pkg::LPOS_W-1:0]           pos_y,
   input  logic [31:0]                          seed,
   output logic signed [vnf_pkg::VALUE_W-1:0]   octave_value
);

   localparam int DIFF_W = vnf_pkg::VALUE_W + 1;
   localparam int PROD_W = vnf_pkg::FADE_W + DIFF_W;

   logic [31:0] ix;
   logic [31:0] iy;
   logic [31:0] ix1;
   logic [31:0] iy1;
   logic signed [vnf_pkg::VALUE_W-1:0] v00;
   logic signed [vnf_pkg::VALUE_W-1:0] v10;
   logic signed [vnf_pkg::VALUE_W-1:0] v01;
   logic signed [vnf_pkg::VALUE_W-1:0] v11;
   logic signed [vnf_pkg::FADE_W-1:0]  sx;
   logic signed [vnf_pkg::FADE_W-1:0]  sy;
   logic signed [DIFF_W-1:0] d0;
   logic signed [DIFF_W-1:0] d1;
   logic signed [PROD_W-1:0] p0_ff;
   logic signed [PROD_W-1:0] p1_ff;
   logic signed [vnf_pkg::VALUE_W-1:0] v00_ff;
   logic signed [vnf_pkg::VALUE_W-1:0] v01_ff;
   logic signed [vnf_pkg::FADE_W-1:0]  sy_ff;
   logic signed [vnf_pkg::VALUE_W-1:0] l0;
   logic signed [vnf_pkg::VALUE_W-1:0] l1;
   logic signed [DIFF_W-1:0] dy;
   logic signed [PROD_W-1:0] q_ff;
   logic signed [vnf_pkg::VALUE_W-1:0] l0_ff;
   logic signed [vnf_pkg::VALUE_W-1:0] value_ff;

   assign ix  = 32'(pos_x[vnf_pkg::LPOS_W-1:vnf_pkg::FRAC_W]);
   assign iy  = 32'(pos_y[vnf_pkg::LPOS_W-1:vnf_pkg::FRAC_W]);
   assign ix1 = ix + 32'd1;
   assign iy1 = iy + 32'd1;

   vnf_hash u_h00 (.clock(clock), .en(en), .x(ix),  .y(iy),  .seed(seed), .value(v00));
   vnf_hash u_h10 (.clock(clock), .en(en), .x(ix1), .y(iy),  .seed(seed), .value(v10));
   vnf_hash u_h01 (.clock(clock), .en(en), .x(ix),  .y(iy1), .seed(seed), .value(v01));
   vnf_hash u_h11 (.clock(clock), .en(en), .x(ix1), .y(iy1), .seed(seed), .value(v11));

   vnf_fade u_fade_x (.clock(clock), .en(en),
                      .frac(pos_x[vnf_pkg::FRAC_W-1:0]), .fade(sx));
   vnf_fade u_fade_y (.clock(clock), .en(en),
                      .frac(pos_y[vnf_pkg::FRAC_W-1:0]), .fade(sy));

   assign d0 = DIFF_W'(v10) - DIFF_W'(v00);
   assign d1 = DIFF_W'(v11) - DIFF_W'(v01);
   assign l0 = v00_ff + vnf_pkg::VALUE_W'(p0_ff >>> vnf_pkg::FRAC_W);
   assign l1 = v01_ff + vnf_pkg::VALUE_W'(p1_ff >>> vnf_pkg::FRAC_W);
   assign dy = DIFF_W'(l1) - DIFF_W'(l0);

   always_ff @(posedge clock) begin
      if (en[vnf_pkg::ST_XLERP]) begin
         p0_ff  <= sx * d0;
         p1_ff  <= sx * d1;
         v00_ff <= v00;
         v01_ff <= v01;
         sy_ff  <= sy;
      end
      if (en[vnf_pkg::ST_YLERP]) begin
         q_ff  <= sy_ff * dy;
         l0_ff <= l0;
      end
      if (en[vnf_pkg::ST_OCTAVE]) begin
         value_ff <= l0_ff + vnf_pkg::VALUE_W'(q_ff >>> vnf_pkg::FRAC_W);
      end
   end

   assign octave_value = value_ff;

endmodule

/* hdl/value_noise_fbm_tile_classifier_core.sv */
// ============================================================================
// value_noise_fbm_tile_classifier_core: terrain class of a tile from fBm noise
// Scales a tile coordinate into noise space, evaluates all octaves of 2-D
// value noise side by side and compares their weighted sum with two limits.
//
//   channel   direction  handshake          carries
//   req       in         valid / ready      column, row
//   rsp       out        valid / ready      tile_class
//   apb       in         psel/penable/...   seed, scale, dirt_limit, tree_limit
//
// One item enters per cycle unless a stall at the output holds the pipeline;
// each class comes out of the ten register stages of the octave datapath.
// Reset is synchronous and active high; it empties the pipeline and loads the
// register defaults. The pipeline has no clearing pass.
// Each stage holds while the stage after it is full and stalled, so empty
// stages still fill while a finished item waits at the output.
// ============================================================================
module value_noise_fbm_tile_classifier_core (
   input  logic                              clock,
   input  logic                              reset,
   vnf_req_if.sink                           req,
   vnf_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [vnf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [vnf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [vnf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   vnf_pkg::cfg_type      cfg;
   vnf_pkg::stage_en_type en;
   vnf_pkg::stage_en_type v_ff;

   logic [vnf_pkg::POS_W-1:0]  px_ff;
   logic [vnf_pkg::POS_W-1:0]  py_ff;
   logic                       oob_ff [vnf_pkg::ST_SUM+1];
   logic                       oob_in;
   logic [vnf_pkg::LPOS_W-1:0] pos_x [vnf_pkg::OCTAVES];
   logic [vnf_pkg::LPOS_W-1:0] pos_y [vnf_pkg::OCTAVES];
   logic [31:0]                lane_seed [vnf_pkg::OCTAVES];
   logic signed [vnf_pkg::VALUE_W-1:0] lane_value [vnf_pkg::OCTAVES];
   logic signed [vnf_pkg::SUM_W-1:0]   sum_in;
   logic signed [vnf_pkg::SUM_W-1:0]   sum_ff;
   logic signed [vnf_pkg::CMP_W-1:0]   sum_wide;
   vnf_pkg::tile_class_type            class_in;
   vnf_pkg::tile_class_type            class_ff;

   // The register block sees the APB port directly.
   vnf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // A stage may load when it is empty or when its own item moves on.
   always_comb begin
      en[vnf_pkg::ST_CLASS] = !v_ff[vnf_pkg::ST_CLASS] || rsp.ready;
      for (int k = vnf_pkg::ST_CLASS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req.ready = en[vnf_pkg::ST_POS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[vnf_pkg::ST_POS]) begin
            v_ff[vnf_pkg::ST_POS] <= req.valid;
         end
         for (int k = 1; k < vnf_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Tiles outside the grid are rock whatever the noise says.
   assign oob_in = (32'(req.column) >= 32'(vnf_pkg::GRID_WIDTH)) ||
                   (32'(req.row) >= 32'(vnf_pkg::GRID_HEIGHT));

   // Stage 0: sample position in Q.16.
   always_ff @(posedge clock) begin
      if (en[vnf_pkg::ST_POS]) begin
         px_ff <= req.column * cfg.scale;
         py_ff <= req.row * cfg.scale;
         oob_ff[vnf_pkg::ST_POS] <= oob_in;
      end
      for (int k = 1; k <= vnf_pkg::ST_SUM; k++) begin
         if (en[k]) begin
            oob_ff[k] <= oob_ff[k-1];
         end
      end
   end

   // Octave o samples at twice the frequency of octave o-1 and uses its own
   // seed, offset by a fixed step per octave with 32-bit wrap.
   for (genvar o = 0; o < vnf_pkg::OCTAVES; o++) begin : g_lane
      assign pos_x[o]     = vnf_pkg::LPOS_W'(px_ff) << o;
      assign pos_y[o]     = vnf_pkg::LPOS_W'(py_ff) << o;
      assign lane_seed[o] = cfg.seed + 32'(o * vnf_pkg::SEED_STEP);

      vnf_octave_lane u_lane (
         .clock        (clock),
         .en           (en),
         .pos_x        (pos_x[o]),
         .pos_y        (pos_y[o]),
         .seed         (lane_seed[o]),
         .octave_value (lane_value[o])
      );
   end

   // Amplitudes halve per octave; the first octave weighs 2^(OCTAVES-1).
   always_comb begin
      sum_in = '0;
      for (int o = 0; o < vnf_pkg::OCTAVES; o++) begin
         sum_in = sum_in + (vnf_pkg::SUM_W'(lane_value[o]) <<< (vnf_pkg::OCTAVES - 1 - o));
      end
   end

   // The limits were already mapped into sum units, so the class is two
   // signed compares; the dirt test wins when the limits are out of order.
   assign sum_wide = vnf_pkg::CMP_W'(sum_ff);

   always_comb begin
      priority if (oob_ff[vnf_pkg::ST_SUM]) begin
         class_in = vnf_pkg::CLASS_ROCK;
      end else if (sum_wide < cfg.dirt_thr) begin
         class_in = vnf_pkg::CLASS_DIRT;
      end else if (sum_wide < cfg.tree_thr) begin
         class_in = vnf_pkg::CLASS_TREE;
      end else begin
         class_in = vnf_pkg::CLASS_ROCK;
      end
   end

   always_ff @(posedge clock) begin
      if (en[vnf_pkg::ST_SUM]) begin
         sum_ff <= sum_in;
      end
      if (en[vnf_pkg::ST_CLASS]) begin
         class_ff <= class_in;
      end
   end

   assign rsp.valid      = v_ff[vnf_pkg::ST_CLASS];
   assign rsp.tile_class = class_ff;

   // An empty output stage means nothing can block the input.
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !v_ff[vnf_pkg::ST_CLASS] |-> req.ready)
      else $error("input blocked with an empty output stage");

   // An accepted item occupies the first stage on the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_ff[vnf_pkg::ST_POS])
      else $error("accepted item lost at pipeline entry");

   // A full, held stage keeps its octave sum.
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[vnf_pkg::ST_SUM] && !en[vnf_pkg::ST_SUM]) |=> $stable(sum_ff))
      else $error("octave sum changed while its stage was held");

endmodule

/* dv/tb_top.sv */
// ============================================================================
// tb_top: testbench of the value-noise fBm tile classifier
// Sends tile coordinates in random bursts and stalls the class channel on a
// pattern of its own. A scoreboard predicts each tile's terrain class from the
// register settings and checks the classes in order. The run goes through
// several seeds, scales and limit pairs, the extremes among them.
// ============================================================================
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vnf_pkg::*;

   // Predicts terrain classes for accepted coordinates and checks the results.
   class tile_class_scoreboard;
      logic [SEED_W-1:0]  seed;
      logic [SCALE_W-1:0] scale;
      logic [LIMIT_W-1:0] dirt_limit;
      logic [LIMIT_W-1:0] tree_limit;
      tile_class_type     pending_classes[$];
      int                 mismatches;
      int                 checked;

      function void load_defaults();
         seed       = SEED_RST;
         scale      = SCALE_RST;
         dirt_limit = DIRT_LIMIT_RST;
         tree_limit = TREE_LIMIT_RST;
      endfunction

      function void set_register(reg_index_type index, logic [31:0] value);
         case (index)
            REG_SEED:       seed       = value;
            REG_SCALE:      scale      = value[SCALE_W-1:0];
            REG_DIRT_LIMIT: dirt_limit = value[LIMIT_W-1:0];
            REG_TREE_LIMIT: tree_limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // Lattice corner hash, with all products wrapping at 32 bits.
      function longint lattice_value(logic [31:0] x, logic [31:0] y, logic [31:0] s);
         logic [31:0] n;
         logic [31:0] h;
         n = x + y * 32'd57 + s * 32'd131;
         n = (n << 13) ^ n;
         h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
         return longint'((64'd2147483648 - {32'd0, h}) >> 14) - 65536;
      endfunction

      // Smootherstep in Q.16; an arithmetic shift of a signed value floors.
      function longint fade(longint f);
         longint a, b, c, d;
         a = 6 * f - 15 * 65536;
         b = ((f * a) >>> 16) + 10 * 65536;
         c = (f * f) >>> 16;
         d = (c * f) >>> 16;
         return (d * b) >>> 16;
      endfunction

      function longint mix(longint a, longint b, longint t);
         return a + ((t * (b - a)) >>> 16);
      endfunction

      function tile_class_type classify(logic [7:0] column, logic [7:0] row);
         longint      px, py, sum, sx, sy, m;
         logic [31:0] ix, iy, s;
         longint      v00, v10, v01, v11;
         sum = 0;
         m = (64'sd1 <<< OCTAVES) - 1;
         for (int o = 0; o < OCTAVES; o++) begin
            px = (longint'(column) * longint'(scale)) << o;
            py = (longint'(row) * longint'(scale)) << o;
            ix = 32'(px >> 16);
            iy = 32'(py >> 16);
            sx = fade(px & 64'hFFFF);
            sy = fade(py & 64'hFFFF);
            s  = seed + 32'(o * 997);
            v00 = lattice_value(ix, iy, s);
            v10 = lattice_value(ix + 32'd1, iy, s);
            v01 = lattice_value(ix, iy + 32'd1, s);
            v11 = lattice_value(ix + 32'd1, iy + 32'd1, s);
            sum += mix(mix(v00, v10, sx), mix(v01, v11, sx), sy) << (OCTAVES - 1 - o);
         end
         if (sum < m * (2 * longint'(dirt_limit) - 65536)) return CLASS_DIRT;
         else if (sum < m * (2 * longint'(tree_limit) - 65536)) return CLASS_TREE;
         else return CLASS_ROCK;
      endfunction

      function void note_coordinate(logic [7:0] column, logic [7:0] row);
         pending_classes.push_back(classify(column, row));
      endfunction

      function void check_class(logic [CLASS_W-1:0] actual);
         tile_class_type wanted;
         if (pending_classes.size() == 0) begin
            $error("tile_class: unexpected item, actual %0d", actual);
            mismatches++;
            return;
         end
         wanted = pending_classes.pop_front();
         checked++;
         if (actual !== wanted) begin
            $error("tile_class: expected %0d, actual %0d", wanted, actual);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   vnf_req_if req ();
   vnf_rsp_if rsp ();

   tile_class_scoreboard tiles = new();
   int sent;

   value_noise_fbm_tile_classifier_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // The receiver switches at random among three habits: always ready, ready at
   // random, or long stalls broken by short windows.
   initial begin
      int mode, hold;
      rsp.ready = 1'b0;
      hold = 0;
      forever begin
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 64; i++) begin
            @(negedge clock);
            if (mode == 0) begin
               rsp.ready = 1'b1;
            end else if (mode == 1) begin
               rsp.ready = 1'($urandom_range(0, 1));
            end else begin
               if (hold > 0) begin
                  hold--;
               end else begin
                  rsp.ready = ~rsp.ready;
                  hold = rsp.ready ? $urandom_range(0, 3) : $urandom_range(0, 20);
               end
            end
         end
      end
   end

   // Every accepted class goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) tiles.check_class(rsp.tile_class);
   end

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic write_register(reg_index_type index, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = {index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      tiles.set_register(index, value);
   endtask

   // Holds one coordinate on the channel until it is taken.
   task automatic send_coordinate(logic [7:0] column, logic [7:0] row);
      @(negedge clock);
      req.valid = 1'b1; req.column = column; req.row = row;
      do @(posedge clock); while (!req.ready);
      tiles.note_coordinate(column, row);
      sent++;
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req.valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Random coordinates in bursts; many stay near the origin, where the low
   // octaves change slowly and the fraction bits matter most.
   task automatic send_random(int count);
      int burst;
      logic [7:0] c, r;
      while (count > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && count > 0; i++, count--) begin
            if ($urandom_range(0, 3) == 0) begin
               c = 8'($urandom_range(0, 15)); r = 8'($urandom_range(0, 15));
            end else begin
               c = 8'($urandom); r = 8'($urandom);
            end
            send_coordinate(c, r);
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 8));
      end
   endtask

   // All classes back and the pipeline empty before a register changes.
   task automatic drain();
      pause_sender(0);
      while (tiles.pending_classes.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   task automatic set_phase(logic [31:0] seed, logic [15:0] scale,
                            logic [16:0] dirt, logic [16:0] tree);
      drain();
      write_register(REG_SEED, seed);
      write_register(REG_SCALE, {16'd0, scale});
      write_register(REG_DIRT_LIMIT, {15'd0, dirt});
      write_register(REG_TREE_LIMIT, {15'd0, tree});
   endtask

   initial begin
      req.valid  = 1'b0;
      req.column = '0;
      req.row    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      tiles.load_defaults();

      // Directed corners and edges of the grid at the reset settings.
      send_coordinate(8'd0, 8'd0);
      send_coordinate(8'd255, 8'd255);
      send_coordinate(8'd0, 8'd255);
      send_coordinate(8'd255, 8'd0);
      send_coordinate(8'd1, 8'd1);
      send_coordinate(8'd128, 8'd127);
      send_coordinate(8'hAA, 8'h55);
      send_coordinate(8'h55, 8'hAA);
      send_random(200);

      // Zero scale: every tile samples the lattice origin.
      set_phase(32'h8000_0000, 16'd0, 17'd32768, 17'd49152);
      send_coordinate(8'd0, 8'd0);
      send_coordinate(8'd255, 8'd255);
      send_random(60);

      // Largest scale with the most negative and most positive seeds.
      set_phase(32'h7fff_ffff, 16'hFFFF, 17'd40000, 17'd60000);
      send_coordinate(8'd255, 8'd255);
      send_random(230);
      set_phase(32'h8000_0000, 16'hFFFF, 17'd30000, 17'd45000);
      send_random(230);

      // Limits at the extremes: all dirt, then all rock.
      set_phase($urandom, 16'($urandom), 17'd131071, 17'd131071);
      send_random(100);
      set_phase($urandom, 16'($urandom), 17'd0, 17'd0);
      send_random(100);

      // Limits out of order: the dirt test wins where both apply.
      set_phase($urandom, 16'($urandom), 17'd60000, 17'd30000);
      send_random(230);

      // Tight limits around the middle so all three classes show up.
      set_phase($urandom, 16'($urandom_range(256, 8192)), 17'd32000, 17'd34000);
      send_random(230);
      set_phase($urandom, 16'($urandom), 17'($urandom_range(0, 131071)),
                17'($urandom_range(0, 131071)));
      send_random(230);
      set_phase(32'd0, SCALE_RST, DIRT_LIMIT_RST, TREE_LIMIT_RST);
      send_random(230);

      drain();
      $display("Checked %0d terrain classes over %0d coordinates sent,", tiles.checked, sent);
      $display("across ten register settings with bursty input and stalled output.");
      if (tiles.mismatches == 0 && tiles.pending_classes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
